FILE: rtl/hsti_pkg.sv
// Package for the hex string to integer converter: widths, character codes, helpers.
package hsti_pkg;

  // Accumulator width, 8 to 64 bits
  localparam int unsigned VALUE_WIDTH = 64;
  localparam int unsigned OUT_WIDTH   = 64;
  localparam int unsigned CHAR_WIDTH  = 8;
  localparam int unsigned MODE_WIDTH  = 2;
  localparam int unsigned DIGIT_WIDTH = 4;

  typedef logic [VALUE_WIDTH-1:0] value_t;
  typedef logic [CHAR_WIDTH-1:0]  char_t;

  // Target width codes
  typedef enum logic [MODE_WIDTH-1:0] {
    MODE_W8  = 2'd0,
    MODE_W16 = 2'd1,
    MODE_W32 = 2'd2,
    MODE_W64 = 2'd3
  } width_mode_t;

  localparam width_mode_t MODE_RESET = MODE_W64;

  // ASCII codes
  localparam char_t CH_0     = 8'h30;
  localparam char_t CH_9     = 8'h39;
  localparam char_t CH_LO_A  = 8'h61;
  localparam char_t CH_LO_F  = 8'h66;
  localparam char_t CH_UP_A  = 8'h41;
  localparam char_t CH_UP_F  = 8'h46;
  localparam char_t CH_LO_X  = 8'h78;
  localparam char_t CH_UP_X  = 8'h58;
  localparam logic [DIGIT_WIDTH-1:0] DIGIT_TEN = 4'd10;

  // Mask of all valid accumulator bits
  localparam logic [OUT_WIDTH-1:0] VALUE_MASK = OUT_WIDTH'({VALUE_WIDTH{1'b1}});

  // Hex digit decode: valid flag and digit value
  typedef struct packed {
    logic                   valid;
    logic [DIGIT_WIDTH-1:0] digit;
  } hex_digit_t;

  function automatic hex_digit_t hex_decode(input char_t c);
    hex_digit_t r;
    r.valid = 1'b1;
    r.digit = '0;
    if (c >= CH_0 && c <= CH_9) begin
      r.digit = DIGIT_WIDTH'(c - CH_0);
    end else if (c >= CH_LO_A && c <= CH_LO_F) begin
      r.digit = DIGIT_TEN + DIGIT_WIDTH'(c - CH_LO_A);
    end else if (c >= CH_UP_A && c <= CH_UP_F) begin
      r.digit = DIGIT_TEN + DIGIT_WIDTH'(c - CH_UP_A);
    end else begin
      r.valid = 1'b0;
    end
    return r;
  endfunction

  // Largest value allowed for a target width
  function automatic logic [OUT_WIDTH-1:0] width_limit(input width_mode_t m);
    logic [OUT_WIDTH-1:0] lim;
    case (m)
      MODE_W8:  lim = 64'h0000_0000_0000_00FF;
      MODE_W16: lim = 64'h0000_0000_0000_FFFF;
      MODE_W32: lim = 64'h0000_0000_FFFF_FFFF;
      default:  lim = 64'hFFFF_FFFF_FFFF_FFFF;
    endcase
    return lim & VALUE_MASK;
  endfunction

endpackage

FILE: rtl/hsti_ifs.sv
// Channel interfaces for the character input and the parsed result.
interface hsti_in_if
  import hsti_pkg::*;
();
  logic  valid;
  logic  ready;
  char_t char_byte;
  logic  last_char;
  logic  empty_string;

  modport source (output valid, output char_byte, output last_char, output empty_string,
                  input ready);
  modport sink   (input valid, input char_byte, input last_char, input empty_string,
                  output ready);
endinterface

interface hsti_out_if
  import hsti_pkg::*;
();
  logic                 valid;
  logic                 ready;
  logic [OUT_WIDTH-1:0] parsed_value;
  logic                 parse_ok;

  modport source (output valid, output parsed_value, output parse_ok, input ready);
  modport sink   (input valid, input parsed_value, input parse_ok, output ready);
endinterface

FILE: rtl/hex_string_to_integer.sv
// Hex ASCII string to unsigned integer converter, top level.
// The last character is held in the input register before the result register loads.
// Throughput: one character per cycle; the input register and one pass of digit decode,
// shift and range compare set the rate; only a stalled full result register holds input.
// Reset: synchronous active-low rst_n clears the string state and both valid flags,
// and sets the target width to 64 bits.
module hex_string_to_integer
  import hsti_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst_n,
  hsti_in_if.sink               in_ch,
  hsti_out_if.source            out_ch,
  input  logic                  cfg_wr_en,
  input  logic [MODE_WIDTH-1:0] cfg_wr_data
);

  // Input register
  logic  in_valid_r;
  char_t in_char_r;
  logic  in_last_r;
  logic  in_empty_r;

  // String state
  value_t      acc_r, acc_nxt;
  logic [1:0]  pos_r, pos_nxt;
  logic        first_zero_r, first_zero_nxt;
  logic        await_r, await_nxt;
  logic        err_r, err_nxt;
  width_mode_t mode_r;

  // Result register
  logic                 out_valid_r;
  logic [OUT_WIDTH-1:0] out_value_r, out_value_nxt;
  logic                 out_ok_r, out_ok_nxt;

  logic       gives_result;
  logic       advance;
  hex_digit_t dec;
  logic       is_x;
  logic       ok;

  // Stage two moves when its item needs no result slot or the slot frees
  assign gives_result = in_last_r | in_empty_r;
  assign advance      = in_valid_r & (~gives_result | ~out_valid_r | out_ch.ready);
  assign in_ch.ready  = ~in_valid_r | advance;

  assign dec  = hex_decode(in_char_r);
  assign is_x = (in_char_r == CH_LO_X) || (in_char_r == CH_UP_X);

  // Per-character update
  always_comb begin
    acc_nxt        = acc_r;
    pos_nxt        = pos_r;
    first_zero_nxt = first_zero_r;
    await_nxt      = await_r;
    err_nxt        = err_r;
    if (!err_r) begin
      if (pos_r == 2'd1 && first_zero_r && is_x) begin
        await_nxt = 1'b1;
      end else if (!dec.valid) begin
        err_nxt = 1'b1;
      end else if (acc_r[VALUE_WIDTH-1 -: DIGIT_WIDTH] != '0) begin
        err_nxt = 1'b1;
      end else begin
        acc_nxt   = {acc_r[VALUE_WIDTH-DIGIT_WIDTH-1:0], dec.digit};
        await_nxt = 1'b0;
        if (pos_r == 2'd0) begin
          first_zero_nxt = (in_char_r == CH_0);
        end
      end
    end
    if (pos_r != 2'd2) begin
      pos_nxt = pos_r + 2'd1;
    end
    ok = ~err_nxt & ~await_nxt & (OUT_WIDTH'(acc_nxt) <= width_limit(mode_r));
    out_value_nxt = ok ? OUT_WIDTH'(acc_nxt) : '0;
    out_ok_nxt    = ok;
    // Empty string and end of string both drop the state
    if (in_empty_r) begin
      out_value_nxt = '0;
      out_ok_nxt    = 1'b0;
    end
    if (gives_result) begin
      acc_nxt        = '0;
      pos_nxt        = 2'd0;
      first_zero_nxt = 1'b0;
      await_nxt      = 1'b0;
      err_nxt        = 1'b0;
    end
  end

  // Input register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_valid_r <= 1'b0;
    end else if (in_ch.ready) begin
      in_valid_r <= in_ch.valid;
    end
    if (in_ch.ready && in_ch.valid) begin
      in_char_r  <= in_ch.char_byte;
      in_last_r  <= in_ch.last_char;
      in_empty_r <= in_ch.empty_string;
    end
  end

  // String state and configuration
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      acc_r        <= '0;
      pos_r        <= 2'd0;
      first_zero_r <= 1'b0;
      await_r      <= 1'b0;
      err_r        <= 1'b0;
      mode_r       <= MODE_RESET;
    end else begin
      if (advance) begin
        acc_r        <= acc_nxt;
        pos_r        <= pos_nxt;
        first_zero_r <= first_zero_nxt;
        await_r      <= await_nxt;
        err_r        <= err_nxt;
      end
      if (cfg_wr_en) begin
        mode_r <= width_mode_t'(cfg_wr_data);
      end
    end
  end

  // Result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (advance && gives_result) begin
      out_valid_r <= 1'b1;
    end else if (out_ch.ready) begin
      out_valid_r <= 1'b0;
    end
    if (advance && gives_result) begin
      out_value_r <= out_value_nxt;
      out_ok_r    <= out_ok_nxt;
    end
  end

  assign out_ch.valid        = out_valid_r;
  assign out_ch.parsed_value = out_value_r;
  assign out_ch.parse_ok     = out_ok_r;

endmodule

FILE: rtl/hsti_checker.sv
// Port-level assertions for the hex string converter, bound to the top level.
module hsti_checker
  import hsti_pkg::*;
(
  input logic                 clk,
  input logic                 rst_n,
  input logic                 in_ready,
  input logic                 out_valid,
  input logic                 out_ready,
  input logic [OUT_WIDTH-1:0] out_parsed_value,
  input logic                 out_parse_ok
);

  // A stalled result holds its value
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_parsed_value)
                                && $stable(out_parse_ok))
    else $error("result changed while stalled");

  // A failed parse reports zero
  a_fail_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_parse_ok |-> out_parsed_value == '0)
    else $error("failed parse with nonzero value");

  // Reset empties the result register
  a_reset_clears: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("result valid after reset");

  // With no result waiting, input is never held off
  a_ready_free: assert property (@(posedge clk) disable iff (!rst_n)
    !out_valid |-> in_ready)
    else $error("input stalled with empty result register");

endmodule

bind hex_string_to_integer hsti_checker u_hsti_checker (
  .clk              (clk),
  .rst_n            (rst_n),
  .in_ready         (in_ch.ready),
  .out_valid        (out_ch.valid),
  .out_ready        (out_ch.ready),
  .out_parsed_value (out_ch.parsed_value),
  .out_parse_ok     (out_ch.parse_ok)
);
